@@ rtl/core/led_pulse_pattern_driver_core_macros.svh @@
// Assertion macros for the LED pulse/pattern driver core.
// Used by the core modules; expects clk_i and rst_ni in the including scope.
`ifndef LED_PULSE_PATTERN_DRIVER_CORE_MACROS_SVH
`define LED_PULSE_PATTERN_DRIVER_CORE_MACROS_SVH

// Same-cycle implication.
`define LPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lpd_pkg.sv @@
// Shared types, constants and helpers of the LED pulse/pattern driver core.
// No dependencies; used by every other file of the core but the assertion macros.
`default_nettype none

package lpd_pkg;

  localparam int unsigned TickMs       = 10;
  localparam int unsigned PatternDepth = 16;
  localparam int unsigned StoreAw      = $clog2(PatternDepth);
  localparam int unsigned CmpW         = 9;

  localparam int unsigned ReqW   = 3;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned ElapW  = 18;
  localparam int unsigned CfgAw  = 3;
  localparam int unsigned CfgDw  = 16;

  localparam logic [ByteW-1:0] EndMark    = 8'hFF;
  localparam logic [ElapW-1:0] ElapsedMax = '1;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK      = 3'd0,
    REQ_SET       = 3'd1,
    REQ_TOGGLE    = 3'd2,
    REQ_PULSE     = 3'd3,
    REQ_PATTERN   = 3'd4,
    REQ_WRITE     = 3'd5
  } req_type_e;

  typedef enum logic [CfgAw-1:0] {
    CFG_ON_TIME      = 3'd0,
    CFG_OFF_TIME     = 3'd1,
    CFG_SAMPLE_TIME  = 3'd2,
    CFG_CYCLE_LIMIT  = 3'd3,
    CFG_REPEAT       = 3'd4,
    CFG_PLAY_MASK    = 3'd5
  } cfg_idx_e;

  // Run mode, one-hot.
  typedef enum logic [2:0] {
    MODE_MANUAL  = 3'b001,
    MODE_PULSE   = 3'b010,
    MODE_PATTERN = 3'b100
  } mode_e;

  localparam logic [ModeW-1:0] ModeCodeManual  = 2'd0;
  localparam logic [ModeW-1:0] ModeCodePulse   = 2'd1;
  localparam logic [ModeW-1:0] ModeCodePattern = 2'd2;

  typedef struct packed {
    logic [TimeW-1:0] on_time;
    logic [TimeW-1:0] off_time;
    logic [TimeW-1:0] sample_time;
    logic [TimeW-1:0] cycle_limit;
    logic             repeat_forever;
    logic [ByteW-1:0] play_mask;
  } cfg_t;

  typedef struct packed {
    logic               en;
    logic [StoreAw-1:0] addr;
    logic [ByteW-1:0]   data;
  } store_wr_t;

  typedef struct packed {
    logic [ByteW-1:0] cur;
    logic [ByteW-1:0] nxt;
  } store_rd_t;

  function automatic logic [ModeW-1:0] mode_code(mode_e m);
    logic [ModeW-1:0] c;
    case (m)
      MODE_PULSE:   c = ModeCodePulse;
      MODE_PATTERN: c = ModeCodePattern;
      default:      c = ModeCodeManual;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/lpd_if.sv @@
// Valid/ready channel interfaces of the LED pulse/pattern driver core.
// Depends on lpd_pkg for field widths.
`default_nettype none

interface lpd_req_if;
  logic                       valid;
  logic                       ready;
  logic [lpd_pkg::ReqW-1:0]   req_type;
  logic                       level;
  logic [lpd_pkg::IdxW-1:0]   entry_index;
  logic [lpd_pkg::ByteW-1:0]  entry_value;

  modport source (output valid, req_type, level, entry_index, entry_value, input ready);
  modport sink   (input valid, req_type, level, entry_index, entry_value, output ready);
endinterface

interface lpd_res_if;
  logic                       valid;
  logic                       ready;
  logic                       led_level;
  logic [lpd_pkg::ModeW-1:0]  mode_now;

  modport source (output valid, led_level, mode_now, input ready);
  modport sink   (input valid, led_level, mode_now, output ready);
endinterface

interface lpd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lpd_pkg::CfgAw-1:0]  index;
  logic [lpd_pkg::CfgDw-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lpd_store.sv @@
// Pattern store: 1W2R memory with registered reads, valid bits and write forwarding.
// Depends on lpd_pkg and the core assertion macros.
`default_nettype none
`include "led_pulse_pattern_driver_core_macros.svh"

module lpd_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpd_pkg::store_wr_t            wr_i,
  input  logic [lpd_pkg::StoreAw-1:0]   rd_addr_i,
  output lpd_pkg::store_rd_t            rd_o
);

  localparam logic [lpd_pkg::StoreAw-1:0] LastAddr =
    lpd_pkg::StoreAw'(lpd_pkg::PatternDepth - 1);

  logic [lpd_pkg::ByteW-1:0]   mem [lpd_pkg::PatternDepth];
  logic [lpd_pkg::PatternDepth-1:0] vld_q;
  logic [lpd_pkg::StoreAw-1:0] rd_addr_nxt;
  logic [lpd_pkg::ByteW-1:0]   cur_q, nxt_q;

  // The entry after the last one is never used; park that port on entry 0.
  assign rd_addr_nxt = (rd_addr_i == LastAddr) ? '0 : rd_addr_i + lpd_pkg::StoreAw'(1);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Unwritten entries read as the end mark; a same-cycle write is forwarded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cur_q <= lpd_pkg::EndMark;
      nxt_q <= lpd_pkg::EndMark;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (wr_i.en && wr_i.addr == rd_addr_i) begin
        cur_q <= wr_i.data;
      end else if (vld_q[rd_addr_i]) begin
        cur_q <= mem[rd_addr_i];
      end else begin
        cur_q <= lpd_pkg::EndMark;
      end
      if (wr_i.en && wr_i.addr == rd_addr_nxt) begin
        nxt_q <= wr_i.data;
      end else if (vld_q[rd_addr_nxt]) begin
        nxt_q <= mem[rd_addr_nxt];
      end else begin
        nxt_q <= lpd_pkg::EndMark;
      end
    end
  end

  assign rd_o.cur = cur_q;
  assign rd_o.nxt = nxt_q;

  `LPD_ASSERT_NEXT(a_fwd_cur, wr_i.en && wr_i.addr == rd_addr_i, rd_o.cur == $past(wr_i.data), "store write not forwarded to current read")

endmodule

`default_nettype wire

@@ rtl/core/lpd_ctrl.sv @@
// Control state of the driver: mode, LED, time and cycle counters, play index.
// Depends on lpd_pkg and the core assertion macros; drives lpd_store.
`default_nettype none
`include "led_pulse_pattern_driver_core_macros.svh"

module lpd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic [lpd_pkg::ReqW-1:0]      req_type_i,
  input  logic                          level_i,
  input  logic [lpd_pkg::IdxW-1:0]      entry_index_i,
  input  logic [lpd_pkg::ByteW-1:0]     entry_value_i,
  input  lpd_pkg::cfg_t                 cfg_i,
  input  lpd_pkg::store_rd_t            rd_i,
  output lpd_pkg::store_wr_t            wr_o,
  output logic [lpd_pkg::StoreAw-1:0]   rd_addr_o,
  output logic                          led_o,
  output logic [lpd_pkg::ModeW-1:0]     mode_o
);

  localparam logic [lpd_pkg::StoreAw-1:0] LastAddr =
    lpd_pkg::StoreAw'(lpd_pkg::PatternDepth - 1);

  lpd_pkg::mode_e                mode_q, mode_d;
  logic                          led_q, led_d;
  logic [lpd_pkg::ElapW-1:0]     el_q, el_d;
  logic [lpd_pkg::TimeW-1:0]     cd_q, cd_d;
  logic [lpd_pkg::StoreAw-1:0]   pi_q, pi_d;

  logic [lpd_pkg::ElapW:0]       el_sum;
  logic [lpd_pkg::ElapW-1:0]     el_adv;
  logic [lpd_pkg::TimeW:0]       on_off;
  logic [lpd_pkg::TimeW-1:0]     cd_inc;
  logic                          cyc_stop;
  logic                          nxt_last;

  assign el_sum   = {1'b0, el_q} + (lpd_pkg::ElapW + 1)'(lpd_pkg::TickMs);
  assign el_adv   = (el_sum > {1'b0, lpd_pkg::ElapsedMax}) ? lpd_pkg::ElapsedMax
                                                           : el_sum[lpd_pkg::ElapW-1:0];
  assign on_off   = {1'b0, cfg_i.on_time} + {1'b0, cfg_i.off_time};
  assign cd_inc   = (cd_q == '1) ? cd_q : cd_q + lpd_pkg::TimeW'(1);
  assign cyc_stop = !cfg_i.repeat_forever && (cd_inc >= cfg_i.cycle_limit);
  assign nxt_last = (pi_q == LastAddr);

  always_comb begin
    mode_d = mode_q;
    led_d  = led_q;
    el_d   = el_q;
    cd_d   = cd_q;
    pi_d   = pi_q;
    wr_o   = '0;
    if (acc_i) begin
      case (lpd_pkg::req_type_e'(req_type_i))
        lpd_pkg::REQ_TICK: begin
          case (mode_q)
            lpd_pkg::MODE_PULSE: begin
              led_d = (el_q < {2'b00, cfg_i.on_time});
              if (el_q >= {1'b0, on_off}) begin
                if (!cfg_i.repeat_forever) cd_d = cd_inc;
                if (cyc_stop) begin
                  led_d  = 1'b0;
                  mode_d = lpd_pkg::MODE_MANUAL;
                end else begin
                  el_d = '0;
                end
              end else begin
                el_d = el_adv;
              end
            end
            lpd_pkg::MODE_PATTERN: begin
              if (el_q == '0) led_d = |(rd_i.cur & cfg_i.play_mask);
              if (el_adv > {2'b00, cfg_i.sample_time}) begin
                el_d = '0;
                if (!nxt_last && rd_i.nxt != lpd_pkg::EndMark) begin
                  pi_d = pi_q + lpd_pkg::StoreAw'(1);
                end else begin
                  pi_d = '0;
                  if (!cfg_i.repeat_forever) cd_d = cd_inc;
                  if (cyc_stop) begin
                    led_d  = 1'b0;
                    mode_d = lpd_pkg::MODE_MANUAL;
                  end
                end
              end else begin
                el_d = el_adv;
              end
            end
            default: ;
          endcase
        end
        lpd_pkg::REQ_SET: begin
          led_d  = level_i;
          mode_d = lpd_pkg::MODE_MANUAL;
        end
        lpd_pkg::REQ_TOGGLE: begin
          led_d  = ~led_q;
          mode_d = lpd_pkg::MODE_MANUAL;
        end
        lpd_pkg::REQ_PULSE: begin
          el_d   = '0;
          cd_d   = '0;
          mode_d = lpd_pkg::MODE_PULSE;
        end
        lpd_pkg::REQ_PATTERN: begin
          el_d   = '0;
          cd_d   = '0;
          pi_d   = '0;
          mode_d = lpd_pkg::MODE_PATTERN;
        end
        lpd_pkg::REQ_WRITE: begin
          wr_o.en   = (lpd_pkg::CmpW'(entry_index_i) < lpd_pkg::CmpW'(lpd_pkg::PatternDepth));
          wr_o.addr = lpd_pkg::StoreAw'(entry_index_i);
          wr_o.data = entry_value_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lpd_pkg::MODE_MANUAL;
      led_q  <= 1'b0;
      el_q   <= '0;
      cd_q   <= '0;
      pi_q   <= '0;
    end else begin
      mode_q <= mode_d;
      led_q  <= led_d;
      el_q   <= el_d;
      cd_q   <= cd_d;
      pi_q   <= pi_d;
    end
  end

  // Prefetch the entries for the next index so they are ready in the cycle after.
  assign rd_addr_o = pi_d;
  assign led_o     = led_q;
  assign mode_o    = lpd_pkg::mode_code(mode_q);

  `LPD_ASSERT_NEXT(a_pattern_start, acc_i && req_type_i == lpd_pkg::REQ_PATTERN, pi_q == '0 && el_q == '0 && mode_q == lpd_pkg::MODE_PATTERN, "pattern start did not clear play state")
  `LPD_ASSERT_NEXT(a_manual_tick, acc_i && req_type_i == lpd_pkg::REQ_TICK && mode_q == lpd_pkg::MODE_MANUAL, led_q == $past(led_q) && mode_q == lpd_pkg::MODE_MANUAL, "tick changed state in manual mode")

endmodule

`default_nettype wire

@@ rtl/core/led_pulse_pattern_driver_core.sv @@
// LED pulse/pattern driver core: top level, handshake, output and config registers.
// Depends on lpd_pkg, lpd_if, lpd_store, lpd_ctrl and the core assertion macros.
//
//   channel  dir  payload                                        accepted when
//   req_i    in   req_type, level, entry_index, entry_value      valid && ready
//   res_o    out  led_level, mode_now                            valid && ready
//   cfg_i    in   index, data                                    valid && ready
//
// One request per cycle unless a result stalls; one result per request, the cycle after.
// The play-index read of the pattern store is prefetched, so a tick does not wait on it.
// A request is taken while the result register is empty or being drained.
// Reset clears the control state; the store reads as all end marks until written.
// The config channel is always ready.
`default_nettype none
`include "led_pulse_pattern_driver_core_macros.svh"

module led_pulse_pattern_driver_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  lpd_req_if.sink  req_i,
  lpd_res_if.source res_o,
  lpd_cfg_if.sink  cfg_i
);

  lpd_pkg::cfg_t                 cfg_q;
  lpd_pkg::store_wr_t            wr;
  lpd_pkg::store_rd_t            rd;
  logic [lpd_pkg::StoreAw-1:0]   rd_addr;
  logic                          res_valid_q;
  logic                          acc;
  logic                          led;
  logic [lpd_pkg::ModeW-1:0]     mode;

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign acc         = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (acc) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_time        <= '0;
      cfg_q.off_time       <= '0;
      cfg_q.sample_time    <= '0;
      cfg_q.cycle_limit    <= '0;
      cfg_q.repeat_forever <= 1'b0;
      cfg_q.play_mask      <= lpd_pkg::ByteW'(1);
    end else if (cfg_i.valid) begin
      case (lpd_pkg::cfg_idx_e'(cfg_i.index))
        lpd_pkg::CFG_ON_TIME:      cfg_q.on_time        <= cfg_i.data;
        lpd_pkg::CFG_OFF_TIME:     cfg_q.off_time       <= cfg_i.data;
        lpd_pkg::CFG_SAMPLE_TIME:  cfg_q.sample_time    <= cfg_i.data;
        lpd_pkg::CFG_CYCLE_LIMIT:  cfg_q.cycle_limit    <= cfg_i.data;
        lpd_pkg::CFG_REPEAT:       cfg_q.repeat_forever <= cfg_i.data[0];
        lpd_pkg::CFG_PLAY_MASK:    cfg_q.play_mask      <= cfg_i.data[lpd_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  lpd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .req_type_i    (req_i.req_type),
    .level_i       (req_i.level),
    .entry_index_i (req_i.entry_index),
    .entry_value_i (req_i.entry_value),
    .cfg_i         (cfg_q),
    .rd_i          (rd),
    .wr_o          (wr),
    .rd_addr_o     (rd_addr),
    .led_o         (led),
    .mode_o        (mode)
  );

  lpd_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_o      (rd)
  );

  // State only moves on acceptance, which needs a free result slot, so it is the result.
  assign res_o.valid     = res_valid_q;
  assign res_o.led_level = led;
  assign res_o.mode_now  = mode;

  `LPD_ASSERT_NEXT(a_acc_gives_result, acc, res_o.valid, "accepted request produced no result")
  `LPD_ASSERT_NOW(a_no_overrun, res_valid_q && !res_o.ready, !acc, "request accepted over a pending result")

endmodule

`default_nettype wire
